### hdl/swc_pkg.sv
package swc_pkg;

    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEF = 16;

    // Configuration register indexes.
    localparam logic [2:0] REG_GRAVITY      = 3'd0;
    localparam logic [2:0] REG_DRAG         = 3'd1;
    localparam logic [2:0] REG_EVAP_SCALE   = 3'd2;
    localparam logic [2:0] REG_GRAD_SCALE   = 3'd3;
    localparam logic [2:0] REG_VEL_CAP      = 3'd4;
    localparam logic [2:0] REG_DECAY        = 3'd5;
    localparam logic [2:0] REG_DEPTH_FLOOR  = 3'd6;
    localparam logic [2:0] REG_SPREAD_FLOOR = 3'd7;

    // Edge marker codes.
    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_LOW  = 2'd1;
    localparam logic [1:0] EDGE_HIGH = 2'd2;
    localparam logic [1:0] EDGE_BOTH = 2'd3;

    typedef struct packed {
        logic [30:0]        depth_center;
        logic signed [31:0] vel_x_center;
        logic signed [31:0] vel_y_center;
        logic [30:0]        depth_west;
        logic [30:0]        depth_east;
        logic [30:0]        depth_south;
        logic [30:0]        depth_north;
        logic signed [31:0] evap_flux;
        logic               pool_flag;
        logic [1:0]         x_edge;
        logic [1:0]         y_edge;
    } in_item_t;

    typedef struct packed {
        logic [30:0]        depth_next;
        logic signed [31:0] vel_x_next;
        logic signed [31:0] vel_y_next;
    } out_item_t;

    typedef struct packed {
        logic [30:0] gravity_times_step;
        logic [30:0] drag_times_step;
        logic [30:0] evap_scale;
        logic [30:0] grad_scale;
        logic [30:0] velocity_cap;
        logic [16:0] decay_mult;
        logic [30:0] depth_floor;
        logic [30:0] spread_floor;
    } cfg_t;

    // Result classification that travels beside the divider.
    typedef struct packed {
        logic zero_all;
        logic zero_vel;
    } flags_t;

    // Unsigned 32-bit value as a 33-bit signed operand.
    function automatic logic signed [32:0] u2s33(input logic [31:0] x);
        return $signed({1'b0, x});
    endfunction

    // Full signed product of two 33-bit operands.
    function automatic logic signed [65:0] mul33(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        return a * b;
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat_s32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Saturate to the depth range [0, 2^31-1].
    function automatic logic [30:0] sat_dep(input logic signed [65:0] x);
        logic [30:0] r;
        if (x < 66'sd0) begin
            r = '0;
        end else if (x > 66'sd2147483647) begin
            r = '1;
        end else begin
            r = x[30:0];
        end
        return r;
    endfunction

endpackage

### hdl/swc_front.sv
module swc_front
    import swc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int DW = 32 + FRAC_BITS
) (
    input  logic          clk,
    input  logic          en,
    input  cfg_t          cfg,
    input  in_item_t      in_data,
    output logic [30:0]   depth_out,
    output flags_t        flags,
    output logic [DW-1:0] num_x,
    output logic [DW-1:0] num_y,
    output logic          neg_x,
    output logic          neg_y
);

    // Depth difference for one direction, chosen by the edge marker.
    function automatic logic signed [31:0] edge_diff(input logic [30:0] c,
                                                     input logic [30:0] lo,
                                                     input logic [30:0] hi,
                                                     input logic [1:0]  mark);
        logic signed [31:0] r;
        case (mark)
            EDGE_NONE: r = $signed({1'b0, hi}) - $signed({1'b0, lo});
            EDGE_LOW:  r = $signed({1'b0, hi}) - $signed({1'b0, c});
            EDGE_HIGH: r = $signed({1'b0, c}) - $signed({1'b0, lo});
            default:   r = '0;
        endcase
        return r;
    endfunction

    // Stage 1 registers.
    logic signed [65:0] s1_p_ev_reg, s1_p_mx_reg, s1_p_my_reg, s1_p_dx_reg, s1_p_dy_reg;
    logic signed [31:0] s1_dfx_reg, s1_dfy_reg;
    logic [31:0]        s1_absu_reg, s1_absv_reg;
    logic [30:0]        s1_h_reg;
    logic               s1_evpos_reg, s1_pool_reg, s1_spread_reg;
    logic [1:0]         s1_xe_reg, s1_ye_reg;

    // Stage 2 registers.
    logic [30:0]        s2_h1_reg, s2_h_reg;
    logic signed [31:0] s2_momx_reg, s2_momy_reg, s2_dvx_reg, s2_dvy_reg;
    logic signed [65:0] s2_p_gx_reg, s2_p_gy_reg;
    logic [31:0]        s2_absu_reg, s2_absv_reg;
    logic               s2_evpos_reg, s2_pool_reg, s2_spread_reg;
    logic [1:0]         s2_xe_reg, s2_ye_reg;

    // Stage 3 registers.
    logic signed [65:0] s3_p_dec_reg, s3_p_d2x_reg, s3_p_d2y_reg;
    logic signed [31:0] s3_gx_reg, s3_gy_reg, s3_momx_reg, s3_momy_reg;
    logic [30:0]        s3_h1_reg, s3_h_reg;
    logic               s3_empty_reg, s3_decay_reg, s3_spread_reg;

    // Stage 4 registers.
    logic [30:0]        s4_h2_reg, s4_h_reg;
    logic signed [31:0] s4_gx_reg, s4_gy_reg, s4_momx_reg, s4_momy_reg;
    logic signed [31:0] s4_dragx_reg, s4_dragy_reg;
    logic               s4_empty_reg, s4_spread_reg;

    // Stage 5 registers.
    logic signed [65:0] s5_p_gh_reg;
    logic [30:0]        s5_h2_reg;
    logic signed [31:0] s5_gx_reg, s5_gy_reg, s5_momx_reg, s5_momy_reg;
    logic signed [31:0] s5_dragx_reg, s5_dragy_reg;
    logic               s5_empty_reg, s5_spread_reg;

    // Stage 6 registers.
    logic signed [65:0] s6_p_px_reg, s6_p_py_reg;
    logic [30:0]        s6_h2_reg;
    logic signed [31:0] s6_momx_reg, s6_momy_reg, s6_dragx_reg, s6_dragy_reg;
    logic               s6_empty_reg, s6_spread_reg;

    // Stage 7 registers.
    logic signed [31:0] s7_mx_reg, s7_my_reg;
    logic [30:0]        s7_h2_reg;
    flags_t             s7_flags_reg;

    // Stage 8 registers.
    logic [DW-1:0]      s8_num_x_reg, s8_num_y_reg;
    logic               s8_neg_x_reg, s8_neg_y_reg;
    logic [30:0]        s8_h2_reg;
    flags_t             s8_flags_reg;

    // Combinational values for stages 1, 7 and 8.
    logic signed [32:0] abs_u, abs_v;
    logic signed [65:0] press_x, press_y;
    logic signed [32:0] abs_mx, abs_my;

    always_comb
    begin
        abs_u  = in_data.vel_x_center[31] ? -33'(in_data.vel_x_center)
                                          : 33'(in_data.vel_x_center);
        abs_v  = in_data.vel_y_center[31] ? -33'(in_data.vel_y_center)
                                          : 33'(in_data.vel_y_center);
        press_x = 66'(sat_s32(s6_p_px_reg >>> FRAC_BITS));
        press_y = 66'(sat_s32(s6_p_py_reg >>> FRAC_BITS));
        abs_mx = s7_mx_reg[31] ? -33'(s7_mx_reg) : 33'(s7_mx_reg);
        abs_my = s7_my_reg[31] ? -33'(s7_my_reg) : 33'(s7_my_reg);
    end

    // Stage 1: evaporation, momentum and drag products, gradient differences.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_p_ev_reg   <= mul33(33'(in_data.evap_flux), u2s33(32'(cfg.evap_scale)));
            s1_p_mx_reg   <= mul33(u2s33(32'(in_data.depth_center)),
                                   33'(in_data.vel_x_center));
            s1_p_my_reg   <= mul33(u2s33(32'(in_data.depth_center)),
                                   33'(in_data.vel_y_center));
            s1_p_dx_reg   <= mul33(u2s33(32'(cfg.drag_times_step)),
                                   33'(in_data.vel_x_center));
            s1_p_dy_reg   <= mul33(u2s33(32'(cfg.drag_times_step)),
                                   33'(in_data.vel_y_center));
            s1_dfx_reg    <= edge_diff(in_data.depth_center, in_data.depth_west,
                                       in_data.depth_east, in_data.x_edge);
            s1_dfy_reg    <= edge_diff(in_data.depth_center, in_data.depth_south,
                                       in_data.depth_north, in_data.y_edge);
            s1_absu_reg   <= abs_u[31:0];
            s1_absv_reg   <= abs_v[31:0];
            s1_h_reg      <= in_data.depth_center;
            s1_evpos_reg  <= (in_data.evap_flux > 32'sd0);
            s1_pool_reg   <= in_data.pool_flag;
            s1_spread_reg <= in_data.pool_flag ||
                             (in_data.depth_center >= cfg.spread_floor);
            s1_xe_reg     <= in_data.x_edge;
            s1_ye_reg     <= in_data.y_edge;
        end
    end

    // Stage 2: evaporated depth, scaled momentum and drag, gradient products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_h1_reg     <= sat_dep(66'($signed({1'b0, s1_h_reg})) +
                                     66'(sat_s32(s1_p_ev_reg >>> FRAC_BITS)));
            s2_momx_reg   <= sat_s32(s1_p_mx_reg >>> FRAC_BITS);
            s2_momy_reg   <= sat_s32(s1_p_my_reg >>> FRAC_BITS);
            s2_dvx_reg    <= sat_s32(s1_p_dx_reg >>> FRAC_BITS);
            s2_dvy_reg    <= sat_s32(s1_p_dy_reg >>> FRAC_BITS);
            s2_p_gx_reg   <= mul33(33'(s1_dfx_reg), u2s33(32'(cfg.grad_scale)));
            s2_p_gy_reg   <= mul33(33'(s1_dfy_reg), u2s33(32'(cfg.grad_scale)));
            s2_absu_reg   <= s1_absu_reg;
            s2_absv_reg   <= s1_absv_reg;
            s2_h_reg      <= s1_h_reg;
            s2_evpos_reg  <= s1_evpos_reg;
            s2_pool_reg   <= s1_pool_reg;
            s2_spread_reg <= s1_spread_reg;
            s2_xe_reg     <= s1_xe_reg;
            s2_ye_reg     <= s1_ye_reg;
        end
    end

    // Stage 3: decay product, gradients, quadratic drag products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_p_dec_reg  <= mul33(u2s33(32'(s2_h1_reg)), u2s33(32'(cfg.decay_mult)));
            s3_gx_reg     <= (s2_xe_reg == EDGE_NONE) ?
                             sat_s32(s2_p_gx_reg >>> (FRAC_BITS + 1)) :
                             sat_s32(s2_p_gx_reg >>> FRAC_BITS);
            s3_gy_reg     <= (s2_ye_reg == EDGE_NONE) ?
                             sat_s32(s2_p_gy_reg >>> (FRAC_BITS + 1)) :
                             sat_s32(s2_p_gy_reg >>> FRAC_BITS);
            s3_p_d2x_reg  <= mul33(33'(s2_dvx_reg), u2s33(s2_absu_reg));
            s3_p_d2y_reg  <= mul33(33'(s2_dvy_reg), u2s33(s2_absv_reg));
            s3_empty_reg  <= !s2_pool_reg && (s2_h1_reg < cfg.depth_floor);
            s3_decay_reg  <= !s2_evpos_reg && (s2_h1_reg != '0);
            s3_momx_reg   <= s2_momx_reg;
            s3_momy_reg   <= s2_momy_reg;
            s3_h1_reg     <= s2_h1_reg;
            s3_h_reg      <= s2_h_reg;
            s3_spread_reg <= s2_spread_reg;
        end
    end

    // Stage 4: decayed depth and drag terms.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_h2_reg     <= s3_decay_reg ? sat_dep(s3_p_dec_reg >>> FRAC_BITS) : s3_h1_reg;
            s4_dragx_reg  <= sat_s32(s3_p_d2x_reg >>> FRAC_BITS);
            s4_dragy_reg  <= sat_s32(s3_p_d2y_reg >>> FRAC_BITS);
            s4_gx_reg     <= s3_gx_reg;
            s4_gy_reg     <= s3_gy_reg;
            s4_momx_reg   <= s3_momx_reg;
            s4_momy_reg   <= s3_momy_reg;
            s4_h_reg      <= s3_h_reg;
            s4_empty_reg  <= s3_empty_reg;
            s4_spread_reg <= s3_spread_reg;
        end
    end

    // Stage 5: average depth times gravity.
    logic [31:0] h_sum;
    assign h_sum = {1'b0, s4_h_reg} + {1'b0, s4_h2_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_p_gh_reg   <= mul33(u2s33(32'(cfg.gravity_times_step)),
                                   u2s33(32'(h_sum[31:1])));
            s5_h2_reg     <= s4_h2_reg;
            s5_gx_reg     <= s4_gx_reg;
            s5_gy_reg     <= s4_gy_reg;
            s5_momx_reg   <= s4_momx_reg;
            s5_momy_reg   <= s4_momy_reg;
            s5_dragx_reg  <= s4_dragx_reg;
            s5_dragy_reg  <= s4_dragy_reg;
            s5_empty_reg  <= s4_empty_reg;
            s5_spread_reg <= s4_spread_reg;
        end
    end

    // Stage 6: pressure products.
    logic signed [31:0] gh5;
    assign gh5 = sat_s32(s5_p_gh_reg >>> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_p_px_reg   <= mul33(33'(gh5), 33'(s5_gx_reg));
            s6_p_py_reg   <= mul33(33'(gh5), 33'(s5_gy_reg));
            s6_h2_reg     <= s5_h2_reg;
            s6_momx_reg   <= s5_momx_reg;
            s6_momy_reg   <= s5_momy_reg;
            s6_dragx_reg  <= s5_dragx_reg;
            s6_dragy_reg  <= s5_dragy_reg;
            s6_empty_reg  <= s5_empty_reg;
            s6_spread_reg <= s5_spread_reg;
        end
    end

    // Stage 7: new momentum and result class.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_mx_reg <= sat_s32(66'(s6_momx_reg) - press_x - 66'(s6_dragx_reg));
            s7_my_reg <= sat_s32(66'(s6_momy_reg) - press_y - 66'(s6_dragy_reg));
            s7_h2_reg <= s6_h2_reg;
            s7_flags_reg.zero_all <= s6_empty_reg ||
                                     (s6_spread_reg && !(s6_h2_reg > cfg.depth_floor));
            s7_flags_reg.zero_vel <= !s6_spread_reg;
        end
    end

    // Stage 8: sign and scaled magnitude for the dividers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_num_x_reg <= {abs_mx[31:0], {FRAC_BITS{1'b0}}};
            s8_num_y_reg <= {abs_my[31:0], {FRAC_BITS{1'b0}}};
            s8_neg_x_reg <= s7_mx_reg[31];
            s8_neg_y_reg <= s7_my_reg[31];
            s8_h2_reg    <= s7_h2_reg;
            s8_flags_reg <= s7_flags_reg;
        end
    end

    assign depth_out = s8_h2_reg;
    assign flags     = s8_flags_reg;
    assign num_x     = s8_num_x_reg;
    assign num_y     = s8_num_y_reg;
    assign neg_x     = s8_neg_x_reg;
    assign neg_y     = s8_neg_y_reg;

endmodule

### hdl/swc_div.sv
module swc_div
    import swc_pkg::*;
#(
    parameter int DW = 32 + FRAC_BITS_DEF,
    parameter int TW = 1
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] num,
    input  logic [30:0]   den,
    input  logic [TW-1:0] tag,
    output logic [DW-1:0] quo,
    output logic [TW-1:0] tag_out
);

    // One quotient bit per stage; the numerator register fills with quotient bits.
    logic [DW-1:0] n_reg [DW];
    logic [30:0]   r_reg [DW];
    logic [30:0]   d_reg [DW];
    logic [TW-1:0] t_reg [DW];

    logic [DW-1:0] n_in [DW];
    logic [30:0]   r_in [DW];
    logic [30:0]   d_in [DW];
    logic [TW-1:0] t_in [DW];

    for (genvar j = 0; j < DW; j++)
    begin : g_stage
        logic [31:0] trial;
        logic [31:0] diff;
        logic        ge;

        if (j == 0)
        begin : g_first
            assign n_in[j] = num;
            assign r_in[j] = '0;
            assign d_in[j] = den;
            assign t_in[j] = tag;
        end
        else
        begin : g_next
            assign n_in[j] = n_reg[j-1];
            assign r_in[j] = r_reg[j-1];
            assign d_in[j] = d_reg[j-1];
            assign t_in[j] = t_reg[j-1];
        end

        // Restoring step: shift in the next numerator bit, subtract if it fits.
        assign trial = {r_in[j], n_in[j][DW-1]};
        assign diff  = trial - {1'b0, d_in[j]};
        assign ge    = (trial >= {1'b0, d_in[j]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j] <= ge ? diff[30:0] : trial[30:0];
                n_reg[j] <= {n_in[j][DW-2:0], ge};
                d_reg[j] <= d_in[j];
                t_reg[j] <= t_in[j];
            end
        end
    end

    assign quo     = n_reg[DW-1];
    assign tag_out = t_reg[DW-1];

endmodule

### hdl/shallow_water_cell_update.sv
// Shallow-water cell update: one explicit Euler step for one grid cell.
// Requests enter on in_valid/in_ready carrying the cell stencil (old depth
// and velocities, four neighbor depths, evaporation flux, pool flag, edge
// markers). Results leave on out_valid/out_ready with the new depth and
// velocities. Configuration registers are written through cfg_write,
// cfg_index and cfg_data, one register per cycle; the user must write
// them only while no request is in flight, which the block does not enforce.
// Throughput is one request per cycle while the output is not stalled.
// The pipeline has eight arithmetic stages, one stage for each of the
// 32 + FRAC_BITS quotient bits of the velocity dividers, and the output
// register.
// The whole pipeline advances together; when the output holds a result
// that the receiver does not take, every stage holds and in_ready is low,
// so no request is lost or repeated.
// Reset clears all stage valid bits and loads the configuration registers
// with their defaults.
module shallow_water_cell_update
    import swc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    localparam int DW  = 32 + FRAC_BITS;
    localparam int LAT = 9 + DW;

    cfg_t             cfg_reg;
    logic [LAT-1:0]   vld_reg;
    logic             go;

    logic [30:0]      depth_f;
    flags_t           flags_f;
    logic [DW-1:0]    num_x, num_y, quo_x, quo_y;
    logic             neg_x, neg_y;
    logic [33:0]      tag_x;
    logic [0:0]       tag_y;
    out_item_t        out_reg;
    out_item_t        out_next;

    // Pipeline advance: move unless a result is held at the output.
    assign go        = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = go;
    assign out_valid = vld_reg[LAT-1];
    assign out_data  = out_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gravity_times_step <= '0;
            cfg_reg.drag_times_step    <= '0;
            cfg_reg.evap_scale         <= '0;
            cfg_reg.grad_scale         <= 31'(1) << FRAC_BITS;
            cfg_reg.velocity_cap       <= '0;
            cfg_reg.decay_mult         <= 17'(1) << FRAC_BITS;
            cfg_reg.depth_floor        <= 31'd7;
            cfg_reg.spread_floor       <= 31'd655;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GRAVITY:      cfg_reg.gravity_times_step <= cfg_data;
                REG_DRAG:         cfg_reg.drag_times_step    <= cfg_data;
                REG_EVAP_SCALE:   cfg_reg.evap_scale         <= cfg_data;
                REG_GRAD_SCALE:   cfg_reg.grad_scale         <= cfg_data;
                REG_VEL_CAP:      cfg_reg.velocity_cap       <= cfg_data;
                REG_DECAY:        cfg_reg.decay_mult         <= cfg_data[16:0];
                REG_DEPTH_FLOOR:  cfg_reg.depth_floor        <= cfg_data;
                REG_SPREAD_FLOOR: cfg_reg.spread_floor       <= cfg_data;
                default:          cfg_reg.spread_floor       <= cfg_data;
            endcase
        end
    end

    // Valid bits travel with the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (go)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    swc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .en        (go),
        .cfg       (cfg_reg),
        .in_data   (in_data),
        .depth_out (depth_f),
        .flags     (flags_f),
        .num_x     (num_x),
        .num_y     (num_y),
        .neg_x     (neg_x),
        .neg_y     (neg_y)
    );

    swc_div #(
        .DW (DW),
        .TW (34)
    ) u_div_x (
        .clk     (clk),
        .en      (go),
        .num     (num_x),
        .den     (depth_f),
        .tag     ({depth_f, flags_f, neg_x}),
        .quo     (quo_x),
        .tag_out (tag_x)
    );

    swc_div #(
        .DW (DW),
        .TW (1)
    ) u_div_y (
        .clk     (clk),
        .en      (go),
        .num     (num_y),
        .den     (depth_f),
        .tag     (neg_y),
        .quo     (quo_y),
        .tag_out (tag_y)
    );

    // Clip velocities to the cap, restore sign, apply the zero cases.
    logic [30:0]  h_d;
    flags_t       fl_d;
    logic [30:0]  cx, cy;

    always_comb
    begin
        h_d  = tag_x[33:3];
        fl_d = tag_x[2:1];
        cx   = (quo_x > DW'(cfg_reg.velocity_cap)) ? cfg_reg.velocity_cap : quo_x[30:0];
        cy   = (quo_y > DW'(cfg_reg.velocity_cap)) ? cfg_reg.velocity_cap : quo_y[30:0];
        out_next.depth_next = fl_d.zero_all ? '0 : h_d;
        if (fl_d.zero_all || fl_d.zero_vel)
        begin
            out_next.vel_x_next = '0;
            out_next.vel_y_next = '0;
        end
        else
        begin
            out_next.vel_x_next = tag_x[0] ? -$signed({1'b0, cx}) : $signed({1'b0, cx});
            out_next.vel_y_next = tag_y[0] ? -$signed({1'b0, cy}) : $signed({1'b0, cy});
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            out_reg <= out_next;
        end
    end

endmodule
